FILE: sv/twd_pkg.sv
package twd_pkg;

	typedef enum logic [2:0] {
		OP_CHECK = 3'd0,
		OP_KICK  = 3'd1,
		OP_START = 3'd2,
		OP_STOP  = 3'd3,
		OP_INIT  = 3'd4
	} opcode_t;

	typedef enum logic [2:0] {
		REASON_NONE         = 3'd0,
		REASON_NOT_SLEEPING = 3'd1,
		REASON_INACTIVITY   = 3'd2,
		REASON_STUCK        = 3'd3,
		REASON_BACKWARD     = 3'd4,
		REASON_FORWARD      = 3'd5
	} reason_t;

	localparam int unsigned CNT_W  = 16;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned CFG_W  = 16;
	localparam int unsigned IDX_W  = 3;

	localparam logic [IDX_W-1:0] REG_MISSED_SLEEP_LIMIT = 3'd0;
	localparam logic [IDX_W-1:0] REG_INACTIVITY_LIMIT   = 3'd1;
	localparam logic [IDX_W-1:0] REG_STUCK_TIME_LIMIT   = 3'd2;
	localparam logic [IDX_W-1:0] REG_BACKWARD_GUARD     = 3'd3;
	localparam logic [IDX_W-1:0] REG_FORWARD_GUARD      = 3'd4;
	localparam logic [IDX_W-1:0] REG_JUMP_CHECK_ENABLE  = 3'd5;

	localparam logic [CNT_W-1:0] MISSED_SLEEP_LIMIT_RST = 16'd1000;
	localparam logic [CNT_W-1:0] INACTIVITY_LIMIT_RST   = 16'd36;
	localparam logic [CNT_W-1:0] STUCK_TIME_LIMIT_RST   = 16'd10;
	localparam logic [CNT_W-1:0] BACKWARD_GUARD_RST     = 16'd60;
	localparam logic [CNT_W-1:0] FORWARD_GUARD_RST      = 16'd300;

	typedef struct packed {
		logic [TIME_W-1:0] ref_time;
		logic [CNT_W-1:0]  missed_cnt;
		logic [CNT_W-1:0]  inact_cnt;
		logic [CNT_W-1:0]  stuck_cnt;
		logic              kick_pending;
		logic              armed;
		logic              fired;
		reason_t           reason;
	} wd_state_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

endpackage

FILE: sv/time_and_activity_watchdog_top.sv
// Supervisory watchdog over system time and software activity.
// Requests enter on the s_axis channel: tuser carries the opcode (check, kick,
// start, stop, init) and tdata the missed-sleep flag and the current seconds.
// Every request produces exactly one result on the m_axis channel, carrying
// the latched trip flag and the reason code of the first trip.
// Limits and guards must be written through cfg_we, cfg_index and cfg_data while
// the block is idle (not enforced); writes to unused indexes are dropped.
// A request is held in an input register, where the state update and the trip
// decision are made, and the result is registered. One request is taken per
// cycle while the result register is not stalled by the receiver.
// The rate is set by the single state update per cycle; each request sees the
// state left by the one before it.
// When the receiver stalls, the result register holds and the input register
// fills; s_axis_tready then drops until the result is taken.
// Reset clears all supervision state, restores the default limits and empties
// both registers. Once tripped the block ignores all requests until reset.
module time_and_activity_watchdog_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [39:0]                s_axis_tdata,  // missed_sleep, now_seconds, zero pad
	input  logic [2:0]                 s_axis_tuser,  // opcode
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [7:0]                 m_axis_tdata,  // tripped, trip_reason, zero pad
	input  logic                       cfg_we,
	input  logic [twd_pkg::IDX_W-1:0]  cfg_index,
	input  logic [twd_pkg::CFG_W-1:0]  cfg_data
);

	logic [twd_pkg::CNT_W-1:0] missed_sleep_limit_q;
	logic [twd_pkg::CNT_W-1:0] inactivity_limit_q;
	logic [twd_pkg::CNT_W-1:0] stuck_time_limit_q;
	logic [twd_pkg::CNT_W-1:0] backward_guard_q;
	logic [twd_pkg::CNT_W-1:0] forward_guard_q;
	logic                      jump_check_enable_q;

	logic                       valid_s1;
	twd_pkg::opcode_t           opcode_s1;
	logic                       missed_s1;
	logic [twd_pkg::TIME_W-1:0] now_s1;

	twd_pkg::wd_state_t st_q;
	twd_pkg::wd_state_t st_d;

	logic                 out_valid_q;
	logic                 tripped_q;
	twd_pkg::reason_t     reason_q;

	logic                       advance;
	logic                       abort_chk;
	logic [twd_pkg::CNT_W-1:0]  missed_inc;
	logic [twd_pkg::CNT_W-1:0]  inact_inc;
	logic [twd_pkg::CNT_W-1:0]  stuck_inc;
	logic [twd_pkg::TIME_W-1:0] back_diff;
	logic [twd_pkg::TIME_W-1:0] fwd_diff;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			missed_sleep_limit_q <= twd_pkg::MISSED_SLEEP_LIMIT_RST;
			inactivity_limit_q   <= twd_pkg::INACTIVITY_LIMIT_RST;
			stuck_time_limit_q   <= twd_pkg::STUCK_TIME_LIMIT_RST;
			backward_guard_q     <= twd_pkg::BACKWARD_GUARD_RST;
			forward_guard_q      <= twd_pkg::FORWARD_GUARD_RST;
			jump_check_enable_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				twd_pkg::REG_MISSED_SLEEP_LIMIT: missed_sleep_limit_q <= cfg_data;
				twd_pkg::REG_INACTIVITY_LIMIT:   inactivity_limit_q   <= cfg_data;
				twd_pkg::REG_STUCK_TIME_LIMIT:   stuck_time_limit_q   <= cfg_data;
				twd_pkg::REG_BACKWARD_GUARD:     backward_guard_q     <= cfg_data;
				twd_pkg::REG_FORWARD_GUARD:      forward_guard_q      <= cfg_data;
				twd_pkg::REG_JUMP_CHECK_ENABLE:  jump_check_enable_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			opcode_s1 <= twd_pkg::opcode_t'(s_axis_tuser);
			missed_s1 <= s_axis_tdata[0];
			now_s1    <= s_axis_tdata[32:1];
		end
	end

	assign missed_inc = twd_pkg::sat_inc(st_q.missed_cnt);
	assign inact_inc  = twd_pkg::sat_inc(st_q.inact_cnt);
	assign stuck_inc  = twd_pkg::sat_inc(st_q.stuck_cnt);
	assign back_diff  = st_q.ref_time - now_s1;
	assign fwd_diff   = now_s1 - st_q.ref_time;

	always_comb begin
		st_d      = st_q;
		abort_chk = 1'b0;
		if (!st_q.fired) begin
			case (opcode_s1)
				twd_pkg::OP_CHECK: begin
					if (missed_s1) begin
						st_d.missed_cnt = missed_inc;
						if (missed_inc > missed_sleep_limit_q) begin
							st_d.fired  = 1'b1;
							st_d.reason = twd_pkg::REASON_NOT_SLEEPING;
						end
					end else begin
						st_d.missed_cnt = '0;
						if (st_q.kick_pending) begin
							st_d.inact_cnt    = '0;
							st_d.kick_pending = 1'b0;
						end else if (st_q.armed) begin
							st_d.inact_cnt = inact_inc;
							if (inact_inc > inactivity_limit_q) begin
								st_d.fired  = 1'b1;
								st_d.reason = twd_pkg::REASON_INACTIVITY;
								abort_chk   = 1'b1;
							end
						end
						if (!abort_chk) begin
							if (now_s1 == st_q.ref_time) begin
								st_d.stuck_cnt = stuck_inc;
								if (stuck_inc > stuck_time_limit_q) begin
									st_d.fired  = 1'b1;
									st_d.reason = twd_pkg::REASON_STUCK;
								end
							end else begin
								st_d.stuck_cnt = '0;
								st_d.ref_time  = now_s1;
								if (jump_check_enable_q) begin
									if (now_s1 < st_q.ref_time) begin
										if (back_diff > {16'd0, backward_guard_q}) begin
											st_d.fired    = 1'b1;
											st_d.reason   = twd_pkg::REASON_BACKWARD;
											st_d.ref_time = st_q.ref_time;
										end
									end else if (fwd_diff > {16'd0, forward_guard_q}) begin
										st_d.fired    = 1'b1;
										st_d.reason   = twd_pkg::REASON_FORWARD;
										st_d.ref_time = st_q.ref_time;
									end
								end
							end
						end
					end
				end
				twd_pkg::OP_KICK: begin
					st_d.kick_pending = 1'b1;
				end
				twd_pkg::OP_START: begin
					st_d.kick_pending = 1'b1;
					st_d.armed        = 1'b1;
				end
				twd_pkg::OP_STOP: begin
					st_d.armed = 1'b0;
				end
				twd_pkg::OP_INIT: begin
					st_d.ref_time = now_s1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tripped_q <= st_d.fired;
			reason_q  <= st_d.reason;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, reason_q, tripped_q};

	a_fired_latched : assert property (@(posedge clk) disable iff (!arst_n)
		st_q.fired |=> st_q.fired)
		else $error("trip flag cleared without reset");

	a_reason_matches : assert property (@(posedge clk) disable iff (!arst_n)
		st_q.fired == (st_q.reason != twd_pkg::REASON_NONE))
		else $error("trip reason inconsistent with trip flag");

	a_frozen_state : assert property (@(posedge clk) disable iff (!arst_n)
		st_q.fired |=> $stable(st_q))
		else $error("state changed after trip");

	a_result_tracks_state : assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (tripped_q == st_q.fired))
		else $error("result does not show the latched trip");

endmodule
